### hw/rtl/tlmrp_pkg.sv
// ----------------------------------------------------------------------------
// tlmrp_pkg
// Types and constants for the telemetry report parser.
// ----------------------------------------------------------------------------
package tlmrp_pkg;

	localparam int ANALOG_COUNT_DEF  = 5;
	localparam int DIGITAL_COUNT_DEF = 8;
	localparam int COMMENT_LIMIT_DEF = 64;
	localparam int COMMENT_BASE      = 33;

	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_M     = 8'h4d;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		KIND_SEQ     = 3'd0,
		KIND_ANALOG  = 3'd1,
		KIND_DIGITAL = 3'd2,
		KIND_COMMENT = 3'd3,
		KIND_END     = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		PH_TYPE      = 4'd0,
		PH_HASH      = 4'd1,
		PH_SEQ_FIRST = 4'd2,
		PH_MIC_I     = 4'd3,
		PH_MIC_C     = 4'd4,
		PH_SEQ       = 4'd5,
		PH_AFTER_MIC = 4'd6,
		PH_ANALOG    = 4'd7,
		PH_DIGITAL   = 4'd8,
		PH_COMMENT   = 4'd9
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  index;
		logic [9:0]  value;
		logic        err;
		logic        end_mark;
	} entry_t;

endpackage

### hw/rtl/telemetry_report_parser.sv
// ----------------------------------------------------------------------------
// telemetry_report_parser
// Byte-stream decoder for telemetry reports, at most one field result and one end result per byte.
// ----------------------------------------------------------------------------
// a result is written into the queue at the clock edge that accepts the byte that causes it
// one byte per cycle while msg_stall is low; the parse step is a single state update
// a byte makes up to two results, drained one per cycle while rpt_stall is low from a 4-entry queue
// msg_stall rises only while the queue holds more than two results
// reset (arst_n low) returns the parser to the type letter and empties the queue
module telemetry_report_parser
	import tlmrp_pkg::*;
#(
	parameter int ANALOG_COUNT  = ANALOG_COUNT_DEF,
	parameter int DIGITAL_COUNT = DIGITAL_COUNT_DEF,
	parameter int COMMENT_LIMIT = COMMENT_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       msg_valid,
	output logic       msg_stall,
	input  logic [7:0] message_byte,
	input  logic       final_byte,
	output logic       rpt_valid,
	input  logic       rpt_stall,
	output logic [2:0] field_kind,
	output logic [2:0] field_index,
	output logic [9:0] field_value,
	output logic       parse_error,
	output logic       end_mark
);

	localparam int          QDEPTH    = 4;
	localparam logic [8:0]  KEEP_LIM  = 9'(COMMENT_BASE + COMMENT_LIMIT);
	localparam logic [3:0]  ANA_LAST  = 4'(ANALOG_COUNT);
	localparam logic [3:0]  DIG_LAST  = 4'(DIGITAL_COUNT);

	phase_t      phase_q, phase_d;
	logic [7:0]  pos_q, pos_d;
	logic [9:0]  acc_q, acc_d;
	logic [1:0]  dcnt_q, dcnt_d;
	logic [2:0]  ana_q, ana_d;
	logic [7:0]  bits_q, bits_d;
	logic [3:0]  bcnt_q, bcnt_d;
	logic        err_q, err_d;

	entry_t      queue_q [QDEPTH];
	logic [1:0]  head_q, tail_q;
	logic [2:0]  count_q;

	logic        msg_acc, rpt_acc;
	logic        emit;
	entry_t      fld, slot0, slot1;
	logic [1:0]  push_n;
	logic [9:0]  dig;
	logic        is_dig;
	logic        bad;
	logic [3:0]  bcnt_inc;
	logic [7:0]  bits_new;

	assign msg_stall = (count_q > 3'd2);
	assign msg_acc   = msg_valid && !msg_stall;
	assign rpt_valid = (count_q != 3'd0);
	assign rpt_acc   = rpt_valid && !rpt_stall;

	assign dig      = {6'd0, message_byte[3:0]};
	assign is_dig   = message_byte inside {[CH_ZERO:CH_NINE]};
	assign bcnt_inc = bcnt_q + 4'd1;
	assign bits_new = (message_byte == CH_ONE && !bcnt_q[3]) ?
		(bits_q | (8'd1 << bcnt_q[2:0])) : bits_q;

	// per-byte parse step
	always_comb begin
		phase_d = phase_q;
		pos_d   = (pos_q != 8'hff) ? pos_q + 8'd1 : pos_q;
		acc_d   = acc_q;
		dcnt_d  = dcnt_q;
		ana_d   = ana_q;
		bits_d  = bits_q;
		bcnt_d  = bcnt_q;
		emit    = 1'b0;
		bad     = 1'b0;
		fld     = '{kind: KIND_SEQ, index: 3'd0, value: 10'd0, err: 1'b0, end_mark: 1'b0};
		if (!err_q) begin
			case (phase_q)
				PH_TYPE: begin
					if (message_byte == CH_T) phase_d = PH_HASH;
					else bad = 1'b1;
				end
				PH_HASH: begin
					if (message_byte == CH_HASH) phase_d = PH_SEQ_FIRST;
					else bad = 1'b1;
				end
				PH_SEQ_FIRST: begin
					if (message_byte == CH_M) begin
						phase_d = PH_MIC_I;
					end else if (is_dig) begin
						acc_d   = dig;
						dcnt_d  = 2'd1;
						phase_d = PH_SEQ;
					end else begin
						bad = 1'b1;
					end
				end
				PH_MIC_I: begin
					if (message_byte == CH_I) phase_d = PH_MIC_C;
					else bad = 1'b1;
				end
				PH_MIC_C: begin
					if (message_byte == CH_C) begin
						phase_d = PH_AFTER_MIC;
						emit    = 1'b1;
					end else begin
						bad = 1'b1;
					end
				end
				PH_SEQ, PH_ANALOG: begin
					if (dcnt_q != 2'd3) begin
						if (is_dig) begin
							acc_d  = (acc_q << 3) + (acc_q << 1) + dig;
							dcnt_d = dcnt_q + 2'd1;
						end else begin
							bad = 1'b1;
						end
					end else if (message_byte == CH_COMMA) begin
						acc_d     = 10'd0;
						dcnt_d    = 2'd0;
						emit      = 1'b1;
						fld.value = acc_q;
						if (phase_q == PH_SEQ) begin
							phase_d = PH_ANALOG;
						end else begin
							fld.kind  = KIND_ANALOG;
							fld.index = ana_q;
							if ({1'b0, ana_q} + 4'd1 >= ANA_LAST) begin
								ana_d   = 3'd0;
								phase_d = PH_DIGITAL;
							end else begin
								ana_d = ana_q + 3'd1;
							end
						end
					end else begin
						bad = 1'b1;
					end
				end
				PH_AFTER_MIC: begin
					if (message_byte == CH_COMMA) begin
						phase_d = PH_ANALOG;
					end else if (is_dig) begin
						acc_d   = dig;
						dcnt_d  = 2'd1;
						phase_d = PH_ANALOG;
					end else begin
						bad = 1'b1;
					end
				end
				PH_DIGITAL: begin
					if (message_byte == CH_ZERO || message_byte == CH_ONE) begin
						bits_d = bits_new;
						bcnt_d = bcnt_inc;
						if (bcnt_inc >= DIG_LAST) begin
							phase_d   = PH_COMMENT;
							emit      = 1'b1;
							fld.kind  = KIND_DIGITAL;
							fld.value = {2'd0, bits_new};
						end
					end else begin
						bad = 1'b1;
					end
				end
				PH_COMMENT: begin
					if ({1'b0, pos_q} < KEEP_LIM) begin
						emit      = 1'b1;
						fld.kind  = KIND_COMMENT;
						fld.value = {2'd0, message_byte};
					end
				end
				default: bad = 1'b1;
			endcase
		end
		err_d = err_q | bad;
	end

	// arrange the results of this request into queue slots
	always_comb begin
		entry_t fin;
		fin = '{kind: KIND_END, index: 3'd0, value: 10'd0,
			err: (err_d || phase_d != PH_COMMENT), end_mark: 1'b1};
		slot0  = emit ? fld : fin;
		slot1  = fin;
		push_n = {1'b0, emit} + {1'b0, final_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			pos_q   <= 8'd0;
			acc_q   <= 10'd0;
			dcnt_q  <= 2'd0;
			ana_q   <= 3'd0;
			bits_q  <= 8'd0;
			bcnt_q  <= 4'd0;
			err_q   <= 1'b0;
		end else if (msg_acc) begin
			if (final_byte) begin
				phase_q <= PH_TYPE;
				pos_q   <= 8'd0;
				acc_q   <= 10'd0;
				dcnt_q  <= 2'd0;
				ana_q   <= 3'd0;
				bits_q  <= 8'd0;
				bcnt_q  <= 4'd0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				acc_q   <= acc_d;
				dcnt_q  <= dcnt_d;
				ana_q   <= ana_d;
				bits_q  <= bits_d;
				bcnt_q  <= bcnt_d;
				err_q   <= err_d;
			end
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= 2'd0;
			tail_q  <= 2'd0;
			count_q <= 3'd0;
		end else begin
			if (rpt_acc) head_q <= head_q + 2'd1;
			if (msg_acc) tail_q <= tail_q + push_n;
			count_q <= count_q + (msg_acc ? {1'b0, push_n} : 3'd0) - {2'd0, rpt_acc};
		end
	end

	always_ff @(posedge clk) begin
		if (msg_acc && push_n != 2'd0) queue_q[tail_q] <= slot0;
		if (msg_acc && push_n == 2'd2) queue_q[tail_q + 2'd1] <= slot1;
	end

	assign field_kind  = queue_q[head_q].kind;
	assign field_index = queue_q[head_q].index;
	assign field_value = queue_q[head_q].value;
	assign parse_error = queue_q[head_q].err;
	assign end_mark    = queue_q[head_q].end_mark;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(QDEPTH))
		else $error("result queue overfilled");

	a_end_queued: assert property (@(posedge clk) disable iff (!arst_n)
		msg_acc && final_byte |=> rpt_valid)
		else $error("message end result missing");

	a_err_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		err_q && !(msg_acc && final_byte) |=> $stable(phase_q) && err_q)
		else $error("parser moved after an error");

	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && end_mark |-> field_kind == KIND_END)
		else $error("end mark on a field result");

	a_err_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && parse_error |-> end_mark)
		else $error("error flag on a field result");

endmodule
